/* hw/rtl/assert_macros.svh */
// Assertion macros for the rigid body integrator RTL.
// Each macro expects clk_i and rst_ni in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RBEI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Next-cycle implication, checked outside reset.
`define RBEI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/rbei_pkg.sv */
// Shared types, command encodings and saturation helpers for the
// rigid body integrator. No dependencies.
`default_nettype none

package rbei_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned IN_TDATA_W  = 88;
  localparam int unsigned OUT_TDATA_W = 192;
  localparam int unsigned STEP_W      = 4;

  typedef enum logic [1:0] {
    FN_FORCE,
    FN_TORQUE,
    FN_IMPULSE,
    FN_UPDATE
  } func_e;

  typedef enum logic [2:0] {
    OA_FX, OA_FY, OA_TQ, OA_VX, OA_VY, OA_SP, OA_AX, OA_AY
  } opa_e;

  typedef enum logic [1:0] {
    OB_IMASS, OB_IINER, OB_DT
  } opb_e;

  typedef enum logic [1:0] {
    WS_PROD, WS_AX, WS_AY
  } wsrc_e;

  typedef enum logic [3:0] {
    WD_FX, WD_FY, WD_TQ, WD_VX, WD_VY, WD_SP, WD_PX, WD_PY, WD_RT
  } wdst_e;

  typedef enum logic {
    WM_SET, WM_ADD
  } wmode_e;

  typedef struct packed {
    logic   cap;
    logic   mul_en;
    opa_e   opa;
    opb_e   opb;
    logic   wb_en;
    wsrc_e  wsrc;
    wdst_e  wdst;
    wmode_e wmode;
    logic   clr_sums;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  is_static;
  } sts_t;

  function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v[47:31] == {17{v[47]}}) begin
      r = v[31:0];
    end else begin
      r = v[47] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    logic signed [31:0] r;
    s = {a[31], a} + {b[31], b};
    if (s[32] == s[31]) begin
      r = s[31:0];
    end else begin
      r = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/rbei_datapath.sv */
// Datapath: configuration registers, body state, shared multiplier with
// saturating writeback, and the result register. Uses rbei_pkg.
`default_nettype none

module rbei_datapath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire rbei_pkg::cmd_t                    cmd_i,
  output      rbei_pkg::sts_t                    sts_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [rbei_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [rbei_pkg::DATA_W-1:0]       cfg_wdata_i,
  input  wire logic [rbei_pkg::IN_TDATA_W-1:0]   in_tdata_i,
  input  wire logic [1:0]                        in_tuser_i,
  output      logic [rbei_pkg::OUT_TDATA_W-1:0]  out_tdata_o,
  output      logic                              out_tuser_o
);
  import rbei_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_INV_MASS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_INER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y  = 2'd3;
  localparam logic [30:0]          STATIC_LIMIT = 31'd328;

  logic [30:0]        inv_mass_q, inv_iner_q;
  logic signed [31:0] fx_q, fy_q, tq_q, vx_q, vy_q, sp_q, px_q, py_q, rt_q;
  func_e              func_q;
  logic signed [31:0] ax_q, ay_q;
  logic [16:0]        dt_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] opa, opb, prod_sat, wval, wcur, wnew;
  logic               is_static;

  assign is_static = (inv_mass_q < STATIC_LIMIT);
  assign sts_o     = '{func: func_q, is_static: is_static};

  always_comb begin
    unique case (cmd_i.opa)
      OA_FX:   opa = fx_q;
      OA_FY:   opa = fy_q;
      OA_TQ:   opa = tq_q;
      OA_VX:   opa = vx_q;
      OA_VY:   opa = vy_q;
      OA_SP:   opa = sp_q;
      OA_AX:   opa = ax_q;
      OA_AY:   opa = ay_q;
      default: opa = ax_q;
    endcase
    unique case (cmd_i.opb)
      OB_IMASS: opb = {1'b0, inv_mass_q};
      OB_IINER: opb = {1'b0, inv_iner_q};
      OB_DT:    opb = {15'd0, dt_q};
      default:  opb = {15'd0, dt_q};
    endcase
  end

  assign prod_sat = sat48(prod_q[63:16]);

  always_comb begin
    unique case (cmd_i.wsrc)
      WS_PROD: wval = prod_sat;
      WS_AX:   wval = ax_q;
      WS_AY:   wval = ay_q;
      default: wval = prod_sat;
    endcase
    unique case (cmd_i.wdst)
      WD_FX:   wcur = fx_q;
      WD_FY:   wcur = fy_q;
      WD_TQ:   wcur = tq_q;
      WD_VX:   wcur = vx_q;
      WD_VY:   wcur = vy_q;
      WD_SP:   wcur = sp_q;
      WD_PX:   wcur = px_q;
      WD_PY:   wcur = py_q;
      WD_RT:   wcur = rt_q;
      default: wcur = rt_q;
    endcase
    wnew = (cmd_i.wmode == WM_ADD) ? add_sat(wcur, wval) : wval;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      func_q <= func_e'(in_tuser_i);
      ax_q   <= in_tdata_i[31:0];
      ay_q   <= in_tdata_i[63:32];
      dt_q   <= in_tdata_i[80:64];
    end
    if (cmd_i.mul_en) begin
      prod_q <= opa * opb;
    end
    if (cmd_i.out_load) begin
      out_tdata_o <= {sp_q, rt_q, vy_q, vx_q, py_q, px_q};
      out_tuser_o <= is_static;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_mass_q <= 31'd65536;
      inv_iner_q <= 31'd65536;
      fx_q <= '0; fy_q <= '0; tq_q <= '0;
      vx_q <= '0; vy_q <= '0; sp_q <= '0;
      px_q <= '0; py_q <= '0; rt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_INV_MASS: inv_mass_q <= cfg_wdata_i[30:0];
          CFG_INV_INER: inv_iner_q <= cfg_wdata_i[30:0];
          CFG_START_X:  px_q <= cfg_wdata_i;
          CFG_START_Y:  py_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.wb_en) begin
        unique case (cmd_i.wdst)
          WD_FX:   fx_q <= wnew;
          WD_FY:   fy_q <= wnew;
          WD_TQ:   tq_q <= wnew;
          WD_VX:   vx_q <= wnew;
          WD_VY:   vy_q <= wnew;
          WD_SP:   sp_q <= wnew;
          WD_PX:   px_q <= wnew;
          WD_PY:   py_q <= wnew;
          WD_RT:   rt_q <= wnew;
          default: ;
        endcase
      end
      if (cmd_i.clr_sums) begin
        fx_q <= '0;
        fy_q <= '0;
        tq_q <= '0;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rbei_ctrl.sv */
// Controller: item handshake, step sequencer issuing datapath commands,
// and result valid. Uses rbei_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rbei_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           s_valid_i,
  output      logic           s_ready_o,
  output      logic           m_valid_o,
  input  wire logic           m_ready_i,
  input  wire rbei_pkg::sts_t sts_i,
  output      rbei_pkg::cmd_t cmd_o
);
  import rbei_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_OUT} state_e;

  state_e              state_q;
  logic [STEP_W-1:0]   step_q;
  logic [STEP_W-1:0]   last_step;
  logic                m_valid_q;
  cmd_t                op;

  function automatic cmd_t mk(input logic mul_en, input opa_e opa, input opb_e opb,
                              input logic wb_en, input wsrc_e wsrc, input wdst_e wdst,
                              input wmode_e wmode);
    cmd_t c;
    c          = '0;
    c.mul_en   = mul_en;
    c.opa      = opa;
    c.opb      = opb;
    c.wb_en    = wb_en;
    c.wsrc     = wsrc;
    c.wdst     = wdst;
    c.wmode    = wmode;
    return c;
  endfunction

  always_comb begin
    op        = '0;
    last_step = '0;
    unique case (sts_i.func)
      FN_FORCE: begin
        last_step = 4'd1;
        if (step_q == 4'd0) begin
          op = mk(1'b0, OA_AX, OB_DT, 1'b1, WS_AX, WD_FX, WM_ADD);
        end else begin
          op = mk(1'b0, OA_AX, OB_DT, 1'b1, WS_AY, WD_FY, WM_ADD);
        end
      end
      FN_TORQUE: begin
        op = mk(1'b0, OA_AX, OB_DT, 1'b1, WS_AX, WD_TQ, WM_ADD);
      end
      FN_IMPULSE: begin
        if (!sts_i.is_static) begin
          last_step = 4'd2;
          unique case (step_q)
            4'd0:    op = mk(1'b1, OA_AX, OB_IMASS, 1'b0, WS_PROD, WD_VX, WM_ADD);
            4'd1:    op = mk(1'b1, OA_AY, OB_IMASS, 1'b1, WS_PROD, WD_VX, WM_ADD);
            default: op = mk(1'b0, OA_AY, OB_IMASS, 1'b1, WS_PROD, WD_VY, WM_ADD);
          endcase
        end
      end
      FN_UPDATE: begin
        if (!sts_i.is_static) begin
          last_step = 4'd9;
          unique case (step_q)
            4'd0: op = mk(1'b1, OA_FX, OB_IMASS, 1'b0, WS_PROD, WD_FX, WM_SET);
            4'd1: op = mk(1'b1, OA_FY, OB_IMASS, 1'b1, WS_PROD, WD_FX, WM_SET);
            4'd2: op = mk(1'b1, OA_TQ, OB_IINER, 1'b1, WS_PROD, WD_FY, WM_SET);
            4'd3: op = mk(1'b1, OA_FX, OB_DT,    1'b1, WS_PROD, WD_TQ, WM_SET);
            4'd4: op = mk(1'b1, OA_FY, OB_DT,    1'b1, WS_PROD, WD_VX, WM_ADD);
            4'd5: op = mk(1'b1, OA_TQ, OB_DT,    1'b1, WS_PROD, WD_VY, WM_ADD);
            4'd6: op = mk(1'b1, OA_VX, OB_DT,    1'b1, WS_PROD, WD_SP, WM_ADD);
            4'd7: op = mk(1'b1, OA_VY, OB_DT,    1'b1, WS_PROD, WD_PX, WM_ADD);
            4'd8: op = mk(1'b1, OA_SP, OB_DT,    1'b1, WS_PROD, WD_PY, WM_ADD);
            default: begin
              op          = mk(1'b0, OA_SP, OB_DT, 1'b1, WS_PROD, WD_RT, WM_ADD);
              op.clr_sums = 1'b1;
            end
          endcase
        end
      end
      default: op = '0;
    endcase
  end

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = m_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.cap      = s_valid_i && s_ready_o;
    if (state_q == ST_RUN) begin
      cmd_o     = op;
      cmd_o.cap = 1'b0;
    end
    cmd_o.out_load = (state_q == ST_OUT) && (!m_valid_q || m_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          step_q <= '0;
          if (s_valid_i) begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (step_q == last_step) begin
            state_q <= ST_OUT;
          end else begin
            step_q <= step_q + 4'd1;
          end
        end
        ST_OUT: begin
          if (cmd_o.out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `RBEI_ASSERT_NEXT(a_one_item, s_valid_i && s_ready_o, !s_ready_o, "item accepted while busy")
  `RBEI_ASSERT(a_load_free, cmd_o.out_load |-> (!m_valid_q || m_ready_i), "result overwritten")
  `RBEI_ASSERT(a_step_range, (state_q == ST_RUN) |-> (step_q <= last_step), "step overrun")

endmodule

`default_nettype wire

/* hw/rtl/rigid_body_euler_integrator.sv */
// Top level of the 2D rigid body semi-implicit Euler integrator (Q16.16).
// Instantiates rbei_ctrl and rbei_datapath; uses rbei_pkg.
//
// Usage:
//  - s_axis carries one event per item: tuser selects the event (add force,
//    add torque, apply impulse, update step), tdata holds arg_x, arg_y and
//    step_time. Every item yields exactly one result on m_axis with the
//    body state after the event and the static flag in tuser.
//  - cfg_we_i writes inv_mass, inv_inertia, start_x or start_y (index 0..3);
//    a start write loads that position component. Write only while no
//    item is in flight.
//  - Items are processed one at a time through a single shared 32x32
//    multiplier: update forms nine products and ends with a writeback
//    step, impulse forms two, force and torque only add their arguments,
//    and a static body skips impulse and update. When the sequence ends,
//    the result register loads once it is free and m_axis valid rises.
//  - A stalled result stays in the output register; the block finishes the
//    next item up to its result and holds there until the output is taken.
//  - Reset: state zero, inverse mass and inertia 1.0, no result pending.
`default_nettype none

module rigid_body_euler_integrator (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  // arg_x[31:0], arg_y[63:32], step_time[80:64], zero pad
  input  wire logic [rbei_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // func[1:0]
  input  wire logic [1:0]                        s_axis_tuser,
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // pos_x, pos_y, vel_x, vel_y, angle, spin: 32 bits each from bit 0
  output      logic [rbei_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // is_static[0]
  output      logic                              m_axis_tuser,
  input  wire logic                              cfg_we_i,
  input  wire logic [rbei_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [rbei_pkg::DATA_W-1:0]       cfg_wdata_i
);
  import rbei_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rbei_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  rbei_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_tdata_i  (s_axis_tdata),
    .in_tuser_i  (s_axis_tuser),
    .out_tdata_o (m_axis_tdata),
    .out_tuser_o (m_axis_tuser)
  );

endmodule

`default_nettype wire
